// File: src/iir_direct_form_one_filter_top_defines.svh
// assertion macros for the direct-form-I iir filter checker
// no dependencies
`ifndef IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define IIR1_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir1 assertion failed");

// next-cycle implication, off during reset
`define IIR1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir1 assertion failed");

`endif

// File: src/iir1_pkg.sv
// types and constants for the direct-form-I iir filter
// no dependencies
package iir1_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 35;
    localparam int DVD_W    = ACC_W - 1;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int NUM_COEFF = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam logic signed [COEFF_W-1:0] Q_ONE = 16'sd4096;

    typedef enum logic
    {
        OP_FILTER  = 1'b0,
        OP_PRELOAD = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        REG_FWD_COEFF_0 = 3'd0,
        REG_FWD_COEFF_1 = 3'd1,
        REG_FWD_COEFF_2 = 3'd2,
        REG_FB_COEFF_0  = 3'd3,
        REG_FB_COEFF_1  = 3'd4,
        REG_FB_COEFF_2  = 3'd5,
        REG_FWD_TAPS    = 3'd6,
        REG_FB_TAPS     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [COEFF_W-1:0] divisor;
    } iir1_div_req_t;

    typedef struct packed
    {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } iir1_div_rsp_t;

endpackage

// File: src/iir1_ifs.sv
// valid/ready channels for the iir filter: input word and result word
// depends on iir1_pkg
interface iir1_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic signed [iir1_pkg::SAMPLE_W-1:0] sample;
    logic signed [iir1_pkg::SAMPLE_W-1:0] init_output;

    modport source (output valid, output op, output sample, output init_output, input ready);
    modport sink   (input valid, input op, input sample, input init_output, output ready);
endinterface

interface iir1_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [iir1_pkg::SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// File: src/iir_direct_form_one_filter_top.sv
// direct-form-I iir filter (up to a biquad) with apb coefficient registers
// depends on iir1_pkg, iir1_ifs, iir1_div
//
// usage:
// item channel takes a word with op, sample and init_output. op filter runs one
// sample through the filter; op preload fills both histories and gives no result.
// result channel gives one filtered word per filter op.
// the apb port holds coefficients and tap counts at byte address 4*index;
// write them only while the block is idle.
// a filter word runs each product through ST_MUL and ST_ACC on the shared 16x16
// multiplier (nb + na - 1 products), then ST_DIV_START, then ST_DIV_WAIT for the
// restoring divider (34 quotient bits and its done flag), then ST_DONE to issue
// the result. when either tap count is 0 the sample goes straight to ST_DONE and
// passes through. a preload leaves the block in ST_IDLE.
// item ready is low while a word is at work; one word at a time.
// a finished result waits in an output register; the block already takes the
// next word while it waits, and only holds at its own end if it is still there.
// reset clears the apb registers, histories and the result valid flag.
module iir_direct_form_one_filter_top
#(
    parameter int FWD_TAPS_MAX = 3,
    parameter int FB_TAPS_MAX  = 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    iir1_item_if.sink                         item,
    iir1_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iir1_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [iir1_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [iir1_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import iir1_pkg::*;

    localparam int FWD_IDX_W = (FWD_TAPS_MAX > 2) ? 2 : 1;
    localparam int FB_IDX_W  = (FB_TAPS_MAX > 2) ? 2 : 1;
    localparam logic [1:0] FWD_MAX_C = 2'(FWD_TAPS_MAX);
    localparam logic [1:0] FB_MAX_C  = 2'(FB_TAPS_MAX);

    logic signed [COEFF_W-1:0]  fwd_coeff_reg [NUM_COEFF];
    logic signed [COEFF_W-1:0]  fb_coeff_reg  [NUM_COEFF];
    logic [1:0]                 fwd_taps_reg;
    logic [1:0]                 fb_taps_reg;
    logic signed [SAMPLE_W-1:0] in_hist_reg   [FWD_TAPS_MAX];
    logic signed [SAMPLE_W-1:0] out_hist_reg  [FB_TAPS_MAX];

    state_t                     state_reg, state_next;
    logic [1:0]                 term_idx_reg, term_idx_next;
    logic                       fb_phase_reg, fb_phase_next;
    logic                       bypass_reg;
    logic                       q_neg_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       result_valid_reg;
    logic signed [SAMPLE_W-1:0] result_reg;

    logic [1:0]                 nb, na;
    logic                       accept, is_filter, is_bypass, issue;
    logic signed [COEFF_W-1:0]  coeff_sel;
    logic signed [SAMPLE_W-1:0] hist_sel;
    logic [ACC_W-1:0]           acc_mag;
    logic                       a0_plain;
    logic [COEFF_W-1:0]         a0_mag;
    logic signed [SAMPLE_W-1:0] sat_q;
    logic                       cfg_write;
    reg_idx_t                   cfg_idx;
    iir1_div_req_t              div_req;
    iir1_div_rsp_t              div_rsp;

    // tap counts clamped to the built history depth
    assign nb = (fwd_taps_reg > FWD_MAX_C) ? FWD_MAX_C : fwd_taps_reg;
    assign na = (fb_taps_reg > FB_MAX_C) ? FB_MAX_C : fb_taps_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign is_filter  = (item.op == OP_FILTER);
    assign is_bypass  = (nb == 2'd0) || (na == 2'd0);
    assign issue      = (state_reg == ST_DONE) && (!result_valid_reg || result.ready);

    // apb registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFF; i++)
            begin
                fwd_coeff_reg[i] <= '0;
                fb_coeff_reg[i]  <= '0;
            end
            fwd_taps_reg <= '0;
            fb_taps_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FWD_COEFF_0: fwd_coeff_reg[0] <= pwdata[COEFF_W-1:0];
                REG_FWD_COEFF_1: fwd_coeff_reg[1] <= pwdata[COEFF_W-1:0];
                REG_FWD_COEFF_2: fwd_coeff_reg[2] <= pwdata[COEFF_W-1:0];
                REG_FB_COEFF_0:  fb_coeff_reg[0]  <= pwdata[COEFF_W-1:0];
                REG_FB_COEFF_1:  fb_coeff_reg[1]  <= pwdata[COEFF_W-1:0];
                REG_FB_COEFF_2:  fb_coeff_reg[2]  <= pwdata[COEFF_W-1:0];
                REG_FWD_TAPS:    fwd_taps_reg     <= pwdata[1:0];
                REG_FB_TAPS:     fb_taps_reg      <= pwdata[1:0];
                default:         fwd_taps_reg     <= fwd_taps_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FWD_COEFF_0: prdata = {16'd0, fwd_coeff_reg[0]};
            REG_FWD_COEFF_1: prdata = {16'd0, fwd_coeff_reg[1]};
            REG_FWD_COEFF_2: prdata = {16'd0, fwd_coeff_reg[2]};
            REG_FB_COEFF_0:  prdata = {16'd0, fb_coeff_reg[0]};
            REG_FB_COEFF_1:  prdata = {16'd0, fb_coeff_reg[1]};
            REG_FB_COEFF_2:  prdata = {16'd0, fb_coeff_reg[2]};
            REG_FWD_TAPS:    prdata = {30'd0, fwd_taps_reg};
            REG_FB_TAPS:     prdata = {30'd0, fb_taps_reg};
            default:         prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            term_idx_reg <= '0;
            fb_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_idx_reg <= term_idx_next;
            fb_phase_reg <= fb_phase_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        term_idx_next = term_idx_reg;
        fb_phase_next = fb_phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_filter)
                begin
                    state_next    = is_bypass ? ST_DONE : ST_MUL;
                    term_idx_next = '0;
                    fb_phase_next = 1'b0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!fb_phase_reg)
                begin
                    if (term_idx_reg == nb - 2'd1)
                    begin
                        if (na > 2'd1)
                        begin
                            state_next    = ST_MUL;
                            fb_phase_next = 1'b1;
                            term_idx_next = 2'd1;
                        end
                        else
                        begin
                            state_next = ST_DIV_START;
                        end
                    end
                    else
                    begin
                        state_next    = ST_MUL;
                        term_idx_next = term_idx_reg + 2'd1;
                    end
                end
                else if (term_idx_reg == na - 2'd1)
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    state_next    = ST_MUL;
                    term_idx_next = term_idx_reg + 2'd1;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FWD_TAPS_MAX; i++)
            begin
                in_hist_reg[i] <= '0;
            end
            for (int i = 0; i < FB_TAPS_MAX; i++)
            begin
                out_hist_reg[i] <= '0;
            end
        end
        else if (accept && !is_filter)
        begin
            for (int i = 0; i < FWD_TAPS_MAX; i++)
            begin
                in_hist_reg[i] <= item.sample;
            end
            for (int i = 0; i < FB_TAPS_MAX; i++)
            begin
                out_hist_reg[i] <= item.init_output;
            end
        end
        else if (accept && !is_bypass)
        begin
            for (int i = 1; i < FWD_TAPS_MAX; i++)
            begin
                if (2'(i) < nb)
                begin
                    in_hist_reg[i] <= in_hist_reg[i-1];
                end
            end
            for (int i = 1; i < FB_TAPS_MAX; i++)
            begin
                if (2'(i) < na)
                begin
                    out_hist_reg[i] <= out_hist_reg[i-1];
                end
            end
            in_hist_reg[0] <= item.sample;
        end
        else if (issue && !bypass_reg)
        begin
            out_hist_reg[0] <= sat_q;
        end
    end

    // shared multiply-accumulate
    assign coeff_sel = fb_phase_reg ? fb_coeff_reg[term_idx_reg] : fwd_coeff_reg[term_idx_reg];
    assign hist_sel  = fb_phase_reg ? out_hist_reg[term_idx_reg[FB_IDX_W-1:0]]
                                    : in_hist_reg[term_idx_reg[FWD_IDX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (accept && is_filter)
        begin
            sample_reg <= item.sample;
            bypass_reg <= is_bypass;
            acc_reg    <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= coeff_sel * hist_sel;
        end
        if (state_reg == ST_ACC)
        begin
            if (fb_phase_reg)
            begin
                acc_reg <= acc_reg - {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            else
            begin
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
        if (state_reg == ST_DIV_START)
        begin
            q_neg_reg <= acc_reg[ACC_W-1] ^ (!a0_plain && fb_coeff_reg[0][COEFF_W-1]);
        end
    end

    // division by a0, or by 4096 when a0 is 0 or 1.0
    assign acc_mag  = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign a0_plain = (fb_coeff_reg[0] == '0) || (fb_coeff_reg[0] == Q_ONE);
    assign a0_mag   = a0_plain ? Q_ONE :
                      (fb_coeff_reg[0][COEFF_W-1] ? (~fb_coeff_reg[0] + 1'b1) : fb_coeff_reg[0]);

    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = acc_mag[DVD_W-1:0];
    assign div_req.divisor  = a0_mag;

    iir1_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturate to 16 bits
    always_comb
    begin
        if (q_neg_reg)
        begin
            if (div_rsp.quotient > DVD_W'(32768))
            begin
                sat_q = 16'sh8000;
            end
            else
            begin
                sat_q = ~div_rsp.quotient[SAMPLE_W-1:0] + 1'b1;
            end
        end
        else if (div_rsp.quotient > DVD_W'(32767))
        begin
            sat_q = 16'sh7fff;
        end
        else
        begin
            sat_q = div_rsp.quotient[SAMPLE_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            result_reg <= bypass_reg ? sample_reg : sat_q;
        end
    end

    assign result.valid    = result_valid_reg;
    assign result.filtered = result_reg;

endmodule

// File: src/iir1_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on iir1_pkg
module iir1_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  iir1_pkg::iir1_div_req_t req,
    output iir1_pkg::iir1_div_rsp_t rsp
);
    import iir1_pkg::*;

    logic [DVD_W-1:0]   quo_reg;
    logic [COEFF_W-1:0] rem_reg;
    logic [COEFF_W-1:0] divisor_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COEFF_W:0]   trial;
    logic [COEFF_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[COEFF_W-1:0] : trial[COEFF_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: src/iir1_checker.sv
// port-level checks for the iir filter top, bound to every instance
// depends on iir1_pkg and iir_direct_form_one_filter_top_defines.svh
`include "iir_direct_form_one_filter_top_defines.svh"

module iir1_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              item_op,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [iir1_pkg::SAMPLE_W-1:0]     result_filtered
);
    import iir1_pkg::*;

    // a filter word keeps the block busy on the next cycle
    `IIR1_ASSERT_NEXT(a_filter_busy, clk, rst_n, item_valid && item_ready && item_op == OP_FILTER, !item_ready)
    // a preload never produces a result word
    `IIR1_ASSERT_NEXT(a_preload_quiet, clk, rst_n, item_valid && item_ready && item_op == OP_PRELOAD, !$rose(result_valid) && item_ready)
    // issuing a result frees the input side
    `IIR1_ASSERT_IMPLY(a_result_frees, clk, rst_n, $rose(result_valid), item_ready)
    // a stalled result word holds
    `IIR1_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_filtered))

endmodule

bind iir_direct_form_one_filter_top iir1_checker u_iir1_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_op         (item.op),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_filtered (result.filtered)
);

// File: tb/sv/iir_direct_form_one_filter_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for iir_direct_form_one_filter_top: directed and random words,
// apb coefficient settings, a predictor of the filter and bursty valid/ready traffic
// depends on iir1_pkg, iir1_ifs and the filter rtl
module iir_direct_form_one_filter_top_tb;

    import iir1_pkg::*;

    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_WORDS    = 50;

    typedef struct
    {
        op_t                         op;
        logic signed [SAMPLE_W-1:0]  sample;
        logic signed [SAMPLE_W-1:0]  init_output;
    } filter_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        item_valid = 1'b0;
    logic                        item_op = 1'b0;
    logic signed [SAMPLE_W-1:0]  item_sample = '0;
    logic signed [SAMPLE_W-1:0]  item_init = '0;
    logic                        res_ready = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr = '0;
    logic [APB_DATA_W-1:0]       pwdata = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    iir1_item_if   item_ch ();
    iir1_result_if result_ch ();

    assign item_ch.valid       = item_valid;
    assign item_ch.op          = item_op;
    assign item_ch.sample      = item_sample;
    assign item_ch.init_output = item_init;
    assign result_ch.ready     = res_ready;

    iir_direct_form_one_filter_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the register file and the filter histories
    logic signed [COEFF_W-1:0]  fwd_coef [NUM_COEFF];
    logic signed [COEFF_W-1:0]  fb_coef [NUM_COEFF];
    logic [1:0]                 fwd_taps_cfg;
    logic [1:0]                 fb_taps_cfg;
    logic signed [SAMPLE_W-1:0] x_hist [NUM_COEFF];
    logic signed [SAMPLE_W-1:0] y_hist [NUM_COEFF];

    filter_word_t                pending_words [$];
    logic signed [SAMPLE_W-1:0]  expected_filtered [$];

    int mismatches = 0;
    int words_taken = 0;
    int preload_count = 0;
    int bypass_count = 0;
    int results_seen = 0;
    int settings_count = 0;

    initial
    begin
        for (int i = 0; i < NUM_COEFF; i++)
        begin
            fwd_coef[i] = '0;
            fb_coef[i]  = '0;
            x_hist[i]   = '0;
            y_hist[i]   = '0;
        end
        fwd_taps_cfg = '0;
        fb_taps_cfg  = '0;
    end

    function automatic void filter_step(input filter_word_t w);
        longint acc;
        longint divisor;
        longint quot;
        int nb;
        int na;
        int i;
        nb = fwd_taps_cfg;
        na = fb_taps_cfg;
        words_taken++;
        if (w.op == OP_PRELOAD)
        begin
            preload_count++;
            for (i = 0; i < NUM_COEFF; i++)
            begin
                x_hist[i] = w.sample;
                y_hist[i] = w.init_output;
            end
            return;
        end
        if (nb == 0 || na == 0)
        begin
            bypass_count++;
            expected_filtered.push_back(w.sample);
            return;
        end
        for (i = nb - 1; i > 0; i--)
            x_hist[i] = x_hist[i-1];
        for (i = na - 1; i > 0; i--)
            y_hist[i] = y_hist[i-1];
        x_hist[0] = w.sample;
        acc = 0;
        for (i = 0; i < nb; i++)
            acc += longint'(fwd_coef[i]) * longint'(x_hist[i]);
        for (i = 1; i < na; i++)
            acc -= longint'(fb_coef[i]) * longint'(y_hist[i]);
        if (fb_coef[0] == 0 || fb_coef[0] == Q_ONE)
            divisor = longint'(Q_ONE);
        else
            divisor = longint'(fb_coef[0]);
        quot = acc / divisor;
        if (quot > 32767)
            quot = 32767;
        else if (quot < -32768)
            quot = -32768;
        y_hist[0] = quot[SAMPLE_W-1:0];
        expected_filtered.push_back(quot[SAMPLE_W-1:0]);
    endfunction

    // word driver: bursts of random length, random gaps between them
    filter_word_t offered;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && item_ch.ready)
                filter_step(offered);
            if (!item_valid || item_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    offered = pending_words.pop_front();
                    item_valid  <= 1'b1;
                    item_op     <= offered.op;
                    item_sample <= offered.sample;
                    item_init   <= offered.init_output;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern and one long hold
    int rx_cycle = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    logic signed [SAMPLE_W-1:0] want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (result_ch.valid && res_ready)
            begin
                results_seen++;
                if (expected_filtered.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected filtered word %0d at %0t", result_ch.filtered, $realtime);
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (result_ch.filtered !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("filtered word %0d: expected %0d, got %0d at %0t",
                                     results_seen, want, result_ch.filtered, $realtime);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 120 && pending_words.size() > 8)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                res_ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle >> 7) % 4)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= 1'($urandom_range(0, 1));
                    2:       res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= ((rx_cycle % 8) < 3);
                endcase
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ch.ready) || (result_ch.valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_filtered.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic settle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || expected_filtered.size() != 0 || item_valid);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FWD_COEFF_0: fwd_coef[0] = value;
            REG_FWD_COEFF_1: fwd_coef[1] = value;
            REG_FWD_COEFF_2: fwd_coef[2] = value;
            REG_FB_COEFF_0:  fb_coef[0] = value;
            REG_FB_COEFF_1:  fb_coef[1] = value;
            REG_FB_COEFF_2:  fb_coef[2] = value;
            REG_FWD_TAPS:    fwd_taps_cfg = value[1:0];
            REG_FB_TAPS:     fb_taps_cfg = value[1:0];
        endcase
    endtask

    task automatic apply_setting(input logic signed [15:0] b0, input logic signed [15:0] b1,
                                 input logic signed [15:0] b2, input logic signed [15:0] a0,
                                 input logic signed [15:0] a1, input logic signed [15:0] a2,
                                 input logic [1:0] nb, input logic [1:0] na);
        logic [15:0] vals [8];
        vals = '{b0, b1, b2, a0, a1, a2, 16'(nb), 16'(na)};
        settle();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), vals[i]);
        settings_count++;
    endtask

    task automatic send(input op_t op, input logic signed [15:0] s, input logic signed [15:0] y);
        filter_word_t w;
        w.op = op;
        w.sample = s;
        w.init_output = y;
        pending_words.push_back(w);
    endtask

    function automatic logic signed [15:0] rand_coeff();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_norm();
        case ($urandom_range(0, 9))
            0:       return 16'sh0000;
            1:       return Q_ONE;
            2:       return 16'sh0001;
            3:       return 16'shffff;
            4:       return 16'sh8000;
            5:       return 16'sh7fff;
            6:       return 16'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(2048, 16384))
                                                          : 16'(-int'($urandom_range(2048, 16384)));
        endcase
    endfunction

    function automatic logic [1:0] rand_taps();
        return ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: both tap counts zero, every filter word passes through
        send(OP_FILTER, 16'sh7fff, 16'sh0000);
        send(OP_FILTER, 16'sh8000, 16'sh7fff);
        send(OP_FILTER, 16'sh0000, 16'sh8000);
        send(OP_PRELOAD, 16'sh7fff, 16'sh8000);
        send(OP_FILTER, 16'sh0005, 16'shffff);

        // largest positive sum, saturates high
        apply_setting(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh8000, 2'd3, 2'd3);
        send(OP_PRELOAD, 16'sh7fff, 16'sh7fff);
        send(OP_FILTER, 16'sh7fff, 16'sh0000);
        send(OP_FILTER, 16'sh8000, 16'sh0000);

        // largest negative sum divided by one, saturates low
        apply_setting(16'sh8000, 16'sh8000, 16'sh8000, 16'sh0001, 16'sh7fff, 16'sh7fff, 2'd3, 2'd3);
        send(OP_PRELOAD, 16'sh7fff, 16'sh7fff);
        send(OP_FILTER, 16'sh7fff, 16'sh7fff);

        // tiny sums truncate toward zero
        apply_setting(16'sh0001, 16'sh0000, 16'sh0000, Q_ONE, 16'sh0000, 16'sh0000, 2'd1, 2'd1);
        send(OP_FILTER, 16'shffff, 16'sh0000);
        send(OP_FILTER, -16'sd4097, 16'sh0000);
        send(OP_FILTER, 16'sd4095, 16'sh0000);

        // most negative normalizer
        apply_setting(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000, Q_ONE, 16'sh0000, 2'd2, 2'd2);
        send(OP_FILTER, 16'sh7fff, 16'sh0000);
        send(OP_FILTER, 16'sh8000, 16'sh0000);
        send(OP_FILTER, 16'sd1234, 16'sh0000);

        // one tap count zero: pass through, histories untouched
        apply_setting(16'sh1000, 16'sh1000, 16'sh1000, Q_ONE, 16'sh0000, 16'sh0000, 2'd3, 2'd0);
        send(OP_FILTER, 16'sd1000, 16'sh0000);
        send(OP_FILTER, -16'sd1000, 16'sh0000);
        apply_setting(16'sh1000, 16'sh1000, 16'sh1000, Q_ONE, 16'sh0000, 16'sh0000, 2'd0, 2'd2);
        send(OP_FILTER, 16'sd777, 16'sh0000);

        // plain biquad picking up the history left above
        apply_setting(16'sd4096, 16'sd2048, 16'sd1024, Q_ONE, -16'sd2048, 16'sd1024, 2'd3, 2'd3);
        send(OP_FILTER, 16'sd3000, 16'sh0000);
        send(OP_FILTER, -16'sd3000, 16'sh0000);
        send(OP_PRELOAD, -16'sd500, 16'sd900);
        send(OP_FILTER, 16'sd100, 16'sh0000);
        send(OP_FILTER, 16'sh7fff, 16'sh0000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_setting(rand_coeff(), rand_coeff(), rand_coeff(), rand_norm(),
                          rand_coeff(), rand_coeff(), rand_taps(), rand_taps());
            for (int n = 0; n < PHASE_WORDS; n++)
                send(($urandom_range(0, 9) == 0) ? OP_PRELOAD : OP_FILTER,
                     rand_sample(), ($urandom_range(0, 3) == 0) ? rand_sample() : 16'($urandom));
        end

        settle();
        $display("run covered %0d words (%0d preloads, %0d pass-through) over %0d register settings",
                 words_taken, preload_count, bypass_count, settings_count);
        $display("%0d filtered words checked, long receiver hold %0s",
                 results_seen, long_hold_done ? "applied" : "not reached");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/iir1_pkg.sv
src/iir1_ifs.sv
src/iir1_div.sv
src/iir_direct_form_one_filter_top.sv
src/iir1_checker.sv
tb/sv/iir_direct_form_one_filter_top_tb.sv
